// ----- hw/rtl/usbep0_pkg.sv -----
// Shared types, codes and the descriptor ROM for the endpoint-zero request handler.
// Used by usbep0_front, usbep0_queue, usbep0_back and the top level; no dependencies.
package usbep0_pkg;

	// Bus event codes
	localparam logic [1:0] ACT_SETUP     = 2'd0;
	localparam logic [1:0] ACT_OUT_SHORT = 2'd1;
	localparam logic [1:0] ACT_IN_DONE   = 2'd2;
	localparam logic [1:0] ACT_BUS_RESET = 2'd3;

	// Response codes
	localparam logic [2:0] RESP_DATA    = 3'd0;
	localparam logic [2:0] RESP_ZLP     = 3'd1;
	localparam logic [2:0] RESP_ACK     = 3'd2;
	localparam logic [2:0] RESP_STALL   = 3'd3;
	localparam logic [2:0] RESP_RX_ACK  = 3'd4;
	localparam logic [2:0] RESP_ADDR_OK = 3'd5;
	localparam logic [2:0] RESP_NONE    = 3'd6;

	// bmRequestType kind field (bits 6:5)
	localparam logic [1:0] KIND_STD   = 2'd0;
	localparam logic [1:0] KIND_CLASS = 2'd1;

	// Standard request codes
	localparam logic [7:0] REQ_GET_STATUS  = 8'h00;
	localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
	localparam logic [7:0] REQ_GET_DESC    = 8'h06;
	localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;

	// Class request codes
	localparam logic [7:0] REQ_SET_LINE_CODING = 8'h20;
	localparam logic [7:0] REQ_GET_LINE_CODING = 8'h21;
	localparam logic [7:0] REQ_SET_CTRL_LINE   = 8'h22;

	// Descriptor types
	localparam logic [7:0] DESC_DEVICE    = 8'h01;
	localparam logic [7:0] DESC_CONFIG    = 8'h02;
	localparam logic [7:0] DESC_STRING    = 8'h03;
	localparam logic [7:0] DESC_QUALIFIER = 8'h06;

	// ROM layout
	localparam int RomSize = 133;
	localparam logic [7:0] OFS_QUAL = 8'd0;
	localparam logic [7:0] OFS_DEV  = 8'd10;
	localparam logic [7:0] OFS_CONF = 8'd28;
	localparam logic [7:0] OFS_STAT = 8'd124;
	localparam logic [7:0] OFS_LINE = 8'd126;
	localparam logic [5:0] LEN_QUAL = 6'd10;
	localparam logic [5:0] LEN_DEV  = 6'd18;
	localparam logic [5:0] LEN_CONF = 6'd46;
	localparam logic [5:0] LEN_STAT = 6'd2;
	localparam logic [5:0] LEN_LINE = 6'd7;

	localparam logic [7:0] StrOfs [0:3] = '{8'd74, 8'd78, 8'd112, 8'd120};
	localparam logic [5:0] StrLen [0:3] = '{6'd4, 6'd34, 6'd8, 6'd4};

	localparam logic [7:0] RomBytes [0:RomSize-1] = '{
		// device qualifier
		8'h0A, 8'h06, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h40, 8'h01, 8'h00,
		// device
		8'h12, 8'h01, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h40, 8'h86, 8'h16,
		8'hDE, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h01,
		// configuration
		8'h09, 8'h02, 8'h2E, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'hF0,
		8'h09, 8'h04, 8'h00, 8'h00, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00,
		8'h07, 8'h05, 8'h01, 8'h02, 8'h00, 8'h02, 8'h00,
		8'h07, 8'h05, 8'h82, 8'h02, 8'h00, 8'h02, 8'h00,
		8'h07, 8'h05, 8'h03, 8'h03, 8'h40, 8'h00, 8'h10,
		8'h07, 8'h05, 8'h84, 8'h03, 8'h40, 8'h00, 8'h10,
		// string 0
		8'h04, 8'h03, 8'h09, 8'h04,
		// string 1
		8'h22, 8'h03, 8'h5A, 8'h00, 8'h4F, 8'h00, 8'h4F, 8'h00, 8'h4D, 8'h00,
		8'h20, 8'h00, 8'h43, 8'h00, 8'h6F, 8'h00, 8'h72, 8'h00, 8'h70, 8'h00,
		8'h6F, 8'h00, 8'h72, 8'h00, 8'h61, 8'h00, 8'h74, 8'h00, 8'h69, 8'h00,
		8'h6F, 8'h00, 8'h6E, 8'h00,
		// string 2
		8'h08, 8'h03, 8'h52, 8'h00, 8'h32, 8'h00, 8'h34, 8'h00,
		// string 3
		8'h04, 8'h03, 8'h30, 8'h00,
		// status
		8'h00, 8'h00,
		// line coding
		8'h00, 8'hC2, 8'h01, 8'h00, 8'h00, 8'h00, 8'h08
	};

	// One job: a run of cnt result items, all sharing the status snapshot.
	typedef struct packed {
		logic [2:0] resp;
		logic [7:0] ptr;
		logic [6:0] cnt;
		logic       tend;
		logic [6:0] addr;
		logic       cfg;
		logic       dtr;
	} job_t;

endpackage

// ----- hw/rtl/usbep0_front.sv -----
// Front end: decodes bus events, holds endpoint state, emits one job per event.
// Depends on usbep0_pkg.
module usbep0_front #(
	parameter int MAX_PACKET_BYTES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [1:0]          action,
	input  logic [7:0]          request_type,
	input  logic [7:0]          request_code,
	input  logic [15:0]         request_value,
	input  logic [15:0]         request_length,
	output usbep0_pkg::job_t    job
);

	localparam logic [6:0] MaxPkt = 7'(MAX_PACKET_BYTES);

	logic [6:0] br_q, br_d;
	logic [7:0] ptr_q, ptr_d;
	logic [6:0] held_q, held_d;
	logic       pend_q, pend_d;
	logic [6:0] addr_q, addr_d;
	logic       cfg_q, cfg_d;
	logic       dtr_q, dtr_d;

	logic       start, send;
	logic [7:0] s_ofs;
	logic [5:0] s_len;
	logic [2:0] single_resp;
	logic [6:0] len_cut, base_br, n;
	logic [7:0] base_ptr;
	logic [7:0] dtype, didx;
	logic [1:0] kind;

	assign dtype = request_value[15:8];
	assign didx  = request_value[7:0];
	assign kind  = request_type[6:5];

	always_comb begin
		br_d        = br_q;
		ptr_d       = ptr_q;
		held_d      = held_q;
		pend_d      = pend_q;
		addr_d      = addr_q;
		cfg_d       = cfg_q;
		dtr_d       = dtr_q;
		start       = 1'b0;
		send        = 1'b0;
		s_ofs       = '0;
		s_len       = '0;
		single_resp = usbep0_pkg::RESP_NONE;

		case (action)
			usbep0_pkg::ACT_SETUP: begin
				br_d        = '0;
				single_resp = usbep0_pkg::RESP_STALL;
				if (kind == usbep0_pkg::KIND_STD) begin
					case (request_code)
						usbep0_pkg::REQ_GET_DESC: begin
							if (dtype == usbep0_pkg::DESC_DEVICE) begin
								start = 1'b1;
								s_ofs = usbep0_pkg::OFS_DEV;
								s_len = usbep0_pkg::LEN_DEV;
							end else if (dtype == usbep0_pkg::DESC_CONFIG) begin
								start = 1'b1;
								s_ofs = usbep0_pkg::OFS_CONF;
								s_len = usbep0_pkg::LEN_CONF;
							end else if (dtype == usbep0_pkg::DESC_QUALIFIER) begin
								start = 1'b1;
								s_ofs = usbep0_pkg::OFS_QUAL;
								s_len = usbep0_pkg::LEN_QUAL;
							end else if (dtype == usbep0_pkg::DESC_STRING && didx < 8'd4) begin
								start = 1'b1;
								s_ofs = usbep0_pkg::StrOfs[didx[1:0]];
								s_len = usbep0_pkg::StrLen[didx[1:0]];
							end
						end
						usbep0_pkg::REQ_GET_STATUS: begin
							if (request_length >= 16'd2) begin
								start = 1'b1;
								s_ofs = usbep0_pkg::OFS_STAT;
								s_len = usbep0_pkg::LEN_STAT;
							end else begin
								single_resp = usbep0_pkg::RESP_ACK;
							end
						end
						usbep0_pkg::REQ_SET_ADDRESS: begin
							held_d      = request_value[6:0];
							pend_d      = 1'b1;
							single_resp = usbep0_pkg::RESP_ACK;
						end
						usbep0_pkg::REQ_SET_CONFIG: begin
							cfg_d       = 1'b1;
							single_resp = usbep0_pkg::RESP_ACK;
						end
						default: single_resp = usbep0_pkg::RESP_STALL;
					endcase
				end else if (kind == usbep0_pkg::KIND_CLASS) begin
					case (request_code)
						usbep0_pkg::REQ_GET_LINE_CODING: begin
							start = 1'b1;
							s_ofs = usbep0_pkg::OFS_LINE;
							s_len = usbep0_pkg::LEN_LINE;
						end
						usbep0_pkg::REQ_SET_CTRL_LINE: begin
							dtr_d       = request_value[0];
							single_resp = usbep0_pkg::RESP_ACK;
						end
						usbep0_pkg::REQ_SET_LINE_CODING: single_resp = usbep0_pkg::RESP_ACK;
						default: single_resp = usbep0_pkg::RESP_STALL;
					endcase
				end else begin
					single_resp = usbep0_pkg::RESP_NONE;
				end
			end
			usbep0_pkg::ACT_OUT_SHORT: single_resp = usbep0_pkg::RESP_RX_ACK;
			usbep0_pkg::ACT_IN_DONE: begin
				if (br_q != '0) begin
					send = 1'b1;
				end else if (pend_q) begin
					addr_d      = held_q;
					pend_d      = 1'b0;
					single_resp = usbep0_pkg::RESP_ADDR_OK;
				end
			end
			default: begin
				held_d = '0;
				pend_d = 1'b0;
				cfg_d  = 1'b0;
				addr_d = '0;
				br_d   = '0;
				ptr_d  = '0;
			end
		endcase

		// Cut the descriptor to wLength, then carve off one packet
		len_cut  = (request_length < {10'd0, s_len}) ? request_length[6:0] : {1'b0, s_len};
		base_br  = start ? len_cut : br_q;
		base_ptr = start ? s_ofs : ptr_q;
		n        = (base_br > MaxPkt) ? MaxPkt : base_br;

		job.addr = addr_d;
		job.cfg  = cfg_d;
		job.dtr  = dtr_d;
		job.ptr  = base_ptr;
		job.cnt  = 7'd1;
		job.tend = 1'b0;
		job.resp = single_resp;
		if (start || send) begin
			br_d  = base_br - n;
			ptr_d = base_ptr + {1'b0, n};
			if (n == '0) begin
				job.resp = usbep0_pkg::RESP_ZLP;
				job.tend = 1'b1;
			end else begin
				job.resp = usbep0_pkg::RESP_DATA;
				job.cnt  = n;
				job.tend = (base_br == n);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			br_q   <= '0;
			ptr_q  <= '0;
			held_q <= '0;
			pend_q <= 1'b0;
			addr_q <= '0;
			cfg_q  <= 1'b0;
			dtr_q  <= 1'b0;
		end else if (push) begin
			br_q   <= br_d;
			ptr_q  <= ptr_d;
			held_q <= held_d;
			pend_q <= pend_d;
			addr_q <= addr_d;
			cfg_q  <= cfg_d;
			dtr_q  <= dtr_d;
		end
	end

endmodule

// ----- hw/rtl/usbep0_queue.sv -----
// Two-entry job queue between the decoder and the result streamer.
// Depends on usbep0_pkg.
module usbep0_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  usbep0_pkg::job_t wr_job,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output usbep0_pkg::job_t rd_job
);

	usbep0_pkg::job_t mem_q [0:1];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	assign full   = (count_q == 2'd2);
	assign empty  = (count_q == 2'd0);
	assign rd_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ----- hw/rtl/usbep0_back.sv -----
// Back end: expands one job into its run of result items, one per cycle while out_ready does not stall it.
// Depends on usbep0_pkg; reads the descriptor ROM from it.
module usbep0_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  usbep0_pkg::job_t rd_job,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       response,
	output logic [7:0]       data_byte,
	output logic             last_of_run,
	output logic             transfer_end,
	output logic [6:0]       device_address,
	output logic             configured,
	output logic             host_ready
);

	usbep0_pkg::job_t cur_q;
	logic [6:0] idx_q;
	logic       busy_q, valid_q;
	logic       advance, last;
	logic [7:0] p, rom_b;

	assign pop     = !busy_q && !empty;
	assign advance = busy_q && (!valid_q || out_ready);
	assign last    = (idx_q == cur_q.cnt - 7'd1);
	assign p       = cur_q.ptr + {1'b0, idx_q};
	assign rom_b   = (p < 8'(usbep0_pkg::RomSize)) ? usbep0_pkg::RomBytes[p] : 8'h00;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (advance) begin
				idx_q <= idx_q + 7'd1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
			if (advance) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= rd_job;
		end
		if (advance) begin
			response       <= cur_q.resp;
			data_byte      <= (cur_q.resp == usbep0_pkg::RESP_DATA) ? rom_b : 8'h00;
			last_of_run    <= last;
			transfer_end   <= cur_q.tend;
			device_address <= cur_q.addr;
			configured     <= cur_q.cfg;
			host_ready     <= cur_q.dtr;
		end
	end

endmodule

// ----- hw/rtl/usb_ep0_standard_request_handler_core.sv -----
// Endpoint-zero control request handler: decoder, two-entry job queue, result streamer.
// First result item path: queue entry, job register, output register.
// Throughput: the streamer loads each job, then sends its n result items, one ROM byte per cycle
// while out_ready does not stall it; n is at most MAX_PACKET_BYTES.
// Input is taken while the job queue has a free slot, so decoding overlaps streaming.
// Reset (arst_n low, asynchronous) clears all endpoint state, queue and output valid.
module usb_ep0_standard_request_handler_core #(
	parameter int MAX_PACKET_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  request_type,
	input  logic [7:0]  request_code,
	input  logic [15:0] request_value,
	input  logic [15:0] request_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  response,
	output logic [7:0]  data_byte,
	output logic        last_of_run,
	output logic        transfer_end,
	output logic [6:0]  device_address,
	output logic        configured,
	output logic        host_ready
);

	usbep0_pkg::job_t new_job, head_job;
	logic push, pop, full, empty;

	// Take an event whenever the queue can hold its job
	assign in_ready = !full;
	assign push     = in_valid && in_ready;

	// Decode the event and advance endpoint state on each transfer
	usbep0_front #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.action        (action),
		.request_type  (request_type),
		.request_code  (request_code),
		.request_value (request_value),
		.request_length(request_length),
		.job           (new_job)
	);

	// Hold decoded jobs so decode and streaming stall independently
	usbep0_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_job(new_job),
		.full  (full),
		.pop   (pop),
		.empty (empty),
		.rd_job(head_job)
	);

	// Stream each job out as result items through the output register
	usbep0_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (empty),
		.rd_job        (head_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.response      (response),
		.data_byte     (data_byte),
		.last_of_run   (last_of_run),
		.transfer_end  (transfer_end),
		.device_address(device_address),
		.configured    (configured),
		.host_ready    (host_ready)
	);

endmodule
